@@ sv/paged_seven_segment_scanner_macros.svh @@
// Assertion macros used by the scanner top level.
`ifndef PAGED_SEVEN_SEGMENT_SCANNER_MACROS_SVH
`define PAGED_SEVEN_SEGMENT_SCANNER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PSS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scanner check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scanner check failed");

`endif

@@ sv/pss_pkg.sv @@
// Types, constants and lookup functions of the paged seven-segment scanner.
`timescale 1ns / 1ps
`default_nettype none
package pss_pkg;

    typedef enum logic [1:0] {
        REQ_REFRESH = 2'd0,
        REQ_LOAD    = 2'd1,
        REQ_FORCE   = 2'd2,
        REQ_NEXT    = 2'd3
    } t_req;

    localparam logic [3:0] GLYPH_BLANK     = 4'd12;
    localparam logic [3:0] GLYPH_A         = 4'd10;
    localparam logic [3:0] GLYPH_U         = 4'd11;
    localparam logic [3:0] MASK_RESET      = 4'd3;
    localparam logic [3:0] SELECT_NONE     = 4'hF;
    localparam logic       REG_PAGE_ENABLE = 1'b0;

    typedef struct packed {
        logic       cur_on;
        logic       found;
        logic [1:0] next_page;
    } t_pick;

    typedef struct packed {
        logic       ok;
        logic       drive_valid;
        logic [3:0] digit_select_n;
        logic       dp_on;
        logic [6:0] segments;
    } t_result;

    function automatic logic [6:0] glyph_segments(input logic [3:0] glyph);
        logic [6:0] seg;
        unique case (glyph)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            4'd10:   seg = 7'h77;
            4'd11:   seg = 7'h3E;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

    function automatic logic [3:0] char_to_glyph(input logic [7:0] c);
        logic [3:0] g;
        priority if (c >= 8'h30 && c <= 8'h39) begin
            g = 4'(c - 8'h30);
        end else if (c == 8'h41) begin
            g = GLYPH_A;
        end else if (c == 8'h55) begin
            g = GLYPH_U;
        end else begin
            g = GLYPH_BLANK;
        end
        return g;
    endfunction

endpackage
`default_nettype wire

@@ sv/pss_page_pick.sv @@
// Enabled-page check and next-enabled-page search for the scanner.
`timescale 1ns / 1ps
`default_nettype none
module pss_page_pick
    import pss_pkg::*;
#(
    parameter int PAGES = 4
) (
    input  wire logic [3:0] i_mask,
    input  wire logic [3:0] i_page,
    output t_pick           o_pick
);

    logic [3:0] w_en;
    logic       w_found_hi;
    logic [1:0] w_page_hi;
    logic       w_found_lo;
    logic [1:0] w_page_lo;

    // Only pages 0 to 3 carry an enable bit.
    always_comb begin
        for (int q = 0; q < 4; q++) begin
            w_en[q] = i_mask[q] && (q < PAGES);
        end
    end

    // The search wraps: the first enabled page above the current one wins,
    // otherwise the lowest enabled page, which may be the current one.
    always_comb begin
        w_found_hi = 1'b0;
        w_page_hi  = 2'd0;
        w_found_lo = 1'b0;
        w_page_lo  = 2'd0;
        for (int q = 3; q >= 0; q--) begin
            if (w_en[q] && (4'(q) > i_page)) begin
                w_found_hi = 1'b1;
                w_page_hi  = 2'(q);
            end
            if (w_en[q]) begin
                w_found_lo = 1'b1;
                w_page_lo  = 2'(q);
            end
        end
        o_pick.cur_on    = (i_page < 4'd4) && w_en[i_page[1:0]];
        o_pick.found     = w_found_lo;
        o_pick.next_page = w_found_hi ? w_page_hi : w_page_lo;
    end

endmodule
`default_nettype wire

@@ sv/paged_seven_segment_scanner.sv @@
// Top level of the paged seven-segment scanner with stream and register ports.
//
//  Port group   Dir  Content
//  s_axis       in   requests: refresh, load message, force page, next page
//  m_axis       out  one result beat per request
//  APB          in   page_enable_mask at byte address 0
//
// One request is taken every cycle while no skid beat is held; its result is
// registered at the accepting edge and offered on m_axis next cycle unless it stalls.
// All work is a single combinational pass from the input beat and the page state into
// the output or skid register, so the rate is one beat per cycle without a skid beat.
// A skid register takes one more beat while the output stalls; s_axis_tready then stays
// low until the cycle after the output takes the skid beat.
// Reset is synchronous; it blanks all glyphs, clears points and the scan pointer.
`timescale 1ns / 1ps
`default_nettype none
module paged_seven_segment_scanner
    import pss_pkg::*;
#(
    parameter int PAGES  = 4,
    parameter int DIGITS = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // page[3:0], char_0[11:4], char_1[19:12], char_2[27:20], char_3[35:28],
    // dp_position[43:36], zero[47:44]
    input  wire logic [47:0] s_axis_tdata,
    // req_type[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // segments[6:0], dp_on[7], digit_select_n[11:8], ok[12], zero[15:13]
    output logic [15:0]      m_axis_tdata,
    // drive_valid[0]
    output logic [0:0]       m_axis_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    logic [3:0]    r_mask;
    logic [PW-1:0] r_page;
    logic [CW-1:0] r_col;
    logic [3:0]    r_glyph [PAGES][DIGITS];
    logic [2:0]    r_dp [PAGES];
    logic          r_out_valid;
    t_result       r_out;
    logic          r_skid_valid;
    t_result       r_skid;

    logic [PW-1:0] n_page;
    logic [CW-1:0] n_col;
    t_result       n_res;

    t_req          w_req;
    logic [PW-1:0] w_in_page;
    logic [7:0]    w_char [4];
    logic [7:0]    w_dpp;
    logic          w_in_fire;
    logic          w_out_fire;
    logic          w_load;
    t_pick         w_cur_pick;
    t_pick         w_in_pick;
    logic [PW-1:0] w_show_page;
    logic [3:0]    w_glyph;

    assign w_req = t_req'(s_axis_tuser);
    assign w_dpp = s_axis_tdata[43:36];
    always_comb begin
        for (int d = 0; d < 4; d++) begin
            w_char[d] = s_axis_tdata[4 + 8*d +: 8];
        end
    end

    // A page number at or above the page count addresses page 0.
    assign w_in_page = ({1'b0, s_axis_tdata[3:0]} < 5'(PAGES)) ? PW'(s_axis_tdata[3:0])
                                                                 : '0;

    assign s_axis_tready = !r_skid_valid;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_out_fire    = r_out_valid && m_axis_tready;
    assign w_load        = w_in_fire && (w_req == REQ_LOAD);

    pss_page_pick #(.PAGES(PAGES)) u_cur_pick (
        .i_mask (r_mask),
        .i_page (4'(r_page)),
        .o_pick (w_cur_pick)
    );

    pss_page_pick #(.PAGES(PAGES)) u_in_pick (
        .i_mask (r_mask),
        .i_page (4'(w_in_page)),
        .o_pick (w_in_pick)
    );

    assign w_show_page = w_cur_pick.cur_on ? r_page : PW'(w_cur_pick.next_page);
    assign w_glyph     = w_cur_pick.cur_on ? r_glyph[w_show_page][r_col]
                                           : r_glyph[w_show_page][0];

    always_comb begin
        n_page               = r_page;
        n_col                = r_col;
        n_res.segments       = '0;
        n_res.dp_on          = 1'b0;
        n_res.digit_select_n = SELECT_NONE;
        n_res.drive_valid    = 1'b0;
        n_res.ok             = 1'b0;
        unique case (w_req)
            REQ_REFRESH: begin
                n_res.drive_valid = 1'b1;
                if (w_cur_pick.cur_on || w_cur_pick.found) begin
                    n_res.segments = glyph_segments(w_glyph);
                    if (w_cur_pick.cur_on) begin
                        n_res.dp_on = (r_dp[w_show_page] == 3'(r_col) + 3'd1);
                        n_res.digit_select_n = ~(4'd1 << r_col);
                    end else begin
                        n_res.dp_on = (r_dp[w_show_page] == 3'd1);
                        n_res.digit_select_n = ~4'd1;
                    end
                    n_page = w_show_page;
                    if (!w_cur_pick.cur_on || (32'(r_col) + 1 >= DIGITS)) begin
                        n_col = w_cur_pick.cur_on ? '0 : CW'(1 % DIGITS);
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                end
            end
            REQ_LOAD: begin
                n_res.ok = 1'b1;
            end
            REQ_FORCE: begin
                if (w_in_pick.cur_on) begin
                    n_page   = w_in_page;
                    n_col    = '0;
                    n_res.ok = 1'b1;
                end
            end
            REQ_NEXT: begin
                if (w_cur_pick.found) begin
                    n_page   = PW'(w_cur_pick.next_page);
                    n_col    = '0;
                    n_res.ok = 1'b1;
                end
            end
            default: begin
                n_res.ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page <= '0;
            r_col  <= '0;
        end else if (w_in_fire) begin
            r_page <= n_page;
            r_col  <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PAGES; p++) begin
                r_dp[p] <= '0;
                for (int d = 0; d < DIGITS; d++) begin
                    r_glyph[p][d] <= GLYPH_BLANK;
                end
            end
        end else if (w_load) begin
            for (int d = 0; d < DIGITS; d++) begin
                r_glyph[w_in_page][d] <= char_to_glyph(w_char[d]);
            end
            r_dp[w_in_page] <= (w_dpp <= 8'(DIGITS)) ? w_dpp[2:0] : 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_in_fire;
                r_out       <= n_res;
            end
        end else if (w_in_fire) begin
            r_skid       <= n_res;
            r_skid_valid <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.ok, r_out.digit_select_n, r_out.dp_on,
                            r_out.segments};
    assign m_axis_tuser  = r_out.drive_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= MASK_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_PAGE_ENABLE)) begin
            r_mask <= pwdata[3:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PAGE_ENABLE) ? {28'd0, r_mask} : 32'd0;

`include "paged_seven_segment_scanner_macros.svh"

    `PSS_ASSERT_IMPL(a_skid_behind_out, r_skid_valid, r_out_valid)
    `PSS_ASSERT_IMPL(a_col_in_range, 1'b1, 32'(r_col) < DIGITS)
    `PSS_ASSERT_IMPL(a_drive_no_ok, r_out_valid && r_out.drive_valid, !r_out.ok)
    `PSS_ASSERT_IMPL(a_cmd_blank, r_out_valid && !r_out.drive_valid,
                     r_out.digit_select_n == SELECT_NONE && r_out.segments == 7'd0)
    `PSS_ASSERT_IMPL(a_one_digit, r_out_valid && r_out.digit_select_n != SELECT_NONE,
                     $onehot(~r_out.digit_select_n))
    `PSS_ASSERT_NEXT(a_stall_holds_skid, r_skid_valid && !m_axis_tready, r_skid_valid)

endmodule
`default_nettype wire
